// ===== rtl/sfr_pkg.sv =====
// Shared types and constants for the streaming find-and-replace block.
// Used by sfr_front, sfr_queue, sfr_back and substring_find_replace_unit.
`timescale 1ns / 1ps

package sfr_pkg;

  localparam int JOB_BYTES = 8;
  localparam int JOB_W     = JOB_BYTES * 8;
  localparam int CNT_W     = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN   = 3'd0,
    REG_PAT_LEN   = 3'd1,
    REG_REPLACE   = 3'd2,
    REG_REP_LEN   = 3'd3,
    REG_EVERY     = 3'd4
  } sfr_reg_t;

  // one queue entry: up to JOB_BYTES output bytes, oldest in the low byte
  typedef struct packed {
    logic [JOB_W-1:0] data;
    logic [CNT_W-1:0] cnt;
    logic             fin;
  } sfr_job_t;

endpackage

// ===== rtl/sfr_front.sv =====
// Front end: configuration registers, match window and per-word classification.
// Depends on sfr_pkg; produces one sfr_job_t per accepted word that yields output.
`timescale 1ns / 1ps

module sfr_front import sfr_pkg::*; #(
  parameter int PATTERN_MAX = 8,
  parameter int REPLACE_MAX = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  input  logic [7:0]           in_byte,
  input  logic                 in_final,
  input  logic                 q_full,
  output logic                 in_ready,
  output logic                 push,
  output sfr_job_t             push_job
);

  localparam int CW = $clog2(PATTERN_MAX + 1);
  localparam int WW = PATTERN_MAX * 8;

  logic [63:0]      pat_r, rep_r;
  logic [CNT_W-1:0] plen_r, rlen_r;
  logic             every_r;

  logic [WW-1:0]    win_r, win_nxt, app_vec;
  logic [CW-1:0]    wc_r, wc_nxt;
  logic             fd_r, fd_nxt;

  logic [CNT_W-1:0] plen, rlen, wc_app, m;
  logic [PATTERN_MAX-1:0] ok;
  logic             match, accept;
  sfr_job_t         job;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (plen_r == '0) plen = CNT_W'(1);
    else if (plen_r > CNT_W'(PATTERN_MAX)) plen = CNT_W'(PATTERN_MAX);
    else plen = plen_r;
    rlen = (rlen_r > CNT_W'(REPLACE_MAX)) ? CNT_W'(REPLACE_MAX) : rlen_r;
  end

  always_comb begin
    for (int i = 0; i < PATTERN_MAX; i++) begin
      app_vec[i*8 +: 8] = (CW'(i) == wc_r) ? in_byte : win_r[i*8 +: 8];
      ok[i] = (CNT_W'(i) >= plen) || (app_vec[i*8 +: 8] == pat_r[i*8 +: 8]);
    end
  end

  always_comb begin
    wc_app = CNT_W'(wc_r) + CNT_W'(1);
    match  = (wc_app == plen) && (every_r || !fd_r) && (&ok);
    if (in_final) m = wc_app;
    else if (wc_app > plen) m = wc_app - plen + CNT_W'(1);
    else if (wc_app == plen) m = match ? '0 : CNT_W'(1);
    else m = '0;

    job.fin = in_final;
    if (match) begin
      job.data = JOB_W'(rep_r);
      job.cnt  = rlen;
    end else begin
      job.data = JOB_W'(app_vec);
      job.cnt  = m;
    end

    win_nxt = app_vec >> {m, 3'b000};
    wc_nxt  = (in_final || match) ? '0 : CW'(wc_app - m);
    fd_nxt  = in_final ? 1'b0 : (match ? 1'b1 : fd_r);
  end

  assign push     = accept && ((job.cnt != '0) || in_final);
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r   <= '0;
      plen_r  <= CNT_W'(1);
      rep_r   <= '0;
      rlen_r  <= '0;
      every_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN: pat_r   <= cfg_wdata;
        REG_PAT_LEN: plen_r  <= cfg_wdata[CNT_W-1:0];
        REG_REPLACE: rep_r   <= cfg_wdata;
        REG_REP_LEN: rlen_r  <= cfg_wdata[CNT_W-1:0];
        REG_EVERY:   every_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r <= '0;
      fd_r <= 1'b0;
    end else if (accept) begin
      wc_r <= wc_nxt;
      fd_r <= fd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) win_r <= win_nxt;
  end

endmodule

// ===== rtl/sfr_queue.sv =====
// Two-entry job queue between front and back end.
// Depends on sfr_pkg for sfr_job_t.
`timescale 1ns / 1ps

module sfr_queue import sfr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  sfr_job_t push_job,
  input  logic     pop,
  output logic     full,
  output logic     head_valid,
  output sfr_job_t head_job
);

  sfr_job_t   mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full       = (cnt_r == 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_job   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/sfr_back.sv =====
// Back end: walks the head job byte by byte into the registered output word.
// Depends on sfr_pkg for sfr_job_t and widths.
`timescale 1ns / 1ps

module sfr_back import sfr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  sfr_job_t   head_job,
  output logic       pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_byte,
  output logic       out_present,
  output logic       out_end
);

  localparam int IW = $clog2(JOB_BYTES);

  logic [IW-1:0] idx_r;
  logic          vld_r, present_r, end_r;
  logic [7:0]    byte_r;
  logic          issue, last;

  assign issue = head_valid && (!vld_r || out_tready);
  assign last  = (head_job.cnt == '0) || (CNT_W'(idx_r) + CNT_W'(1) == head_job.cnt);
  assign pop   = issue && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else begin
      if (issue) vld_r <= 1'b1;
      else if (out_tready) vld_r <= 1'b0;
      if (pop) idx_r <= '0;
      else if (issue) idx_r <= idx_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      present_r <= (head_job.cnt != '0);
      byte_r    <= (head_job.cnt != '0) ? head_job.data[{idx_r, 3'b000} +: 8] : 8'h00;
      end_r     <= head_job.fin && last;
    end
  end

  assign out_tvalid  = vld_r;
  assign out_byte    = byte_r;
  assign out_present = present_r;
  assign out_end     = end_r;

endmodule

// ===== rtl/substring_find_replace_unit.sv =====
// Top level of the streaming find-and-replace block.
// Depends on sfr_pkg, sfr_front, sfr_queue and sfr_back.
//
// Usage: text enters one byte per word on the in_ channel, in_tlast on the
// last byte of a text. Rewritten text leaves on the out_ channel, one byte
// per word; out_tuser is 0 only on the empty end marker sent when a text
// ends in a match with no replacement; out_tlast flags a text's last word.
// Registers are written through cfg_we/cfg_index/cfg_wdata while idle.
// An accepted input word enters the job queue, then the output register.
// Throughput: one input word per cycle while each word yields at most one
// output word; a word yielding n words (replacement burst or end flush, up
// to 8) holds the output sequencer until all n are sent, and the two-entry
// job queue then fills and drops in_tready.
// Back-pressure on out_tready stalls the sequencer; the front keeps taking
// words until the queue is full.
// Reset (synchronous, rst_n low) empties the window and queue and restores
// register defaults: pattern length 1, empty replacement, replace every.
`timescale 1ns / 1ps

module substring_find_replace_unit import sfr_pkg::*; #(
  parameter int PATTERN_MAX = 8,
  parameter int REPLACE_MAX = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] text_byte
  input  logic                 in_tlast,   // final_byte
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // [7:0] out_byte
  output logic                 out_tuser,  // byte_present
  output logic                 out_tlast   // end_of_text
);

  logic     push, pop, q_full, head_valid;
  sfr_job_t push_job, head_job;

  sfr_front #(
    .PATTERN_MAX(PATTERN_MAX),
    .REPLACE_MAX(REPLACE_MAX)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_byte   (in_tdata),
    .in_final  (in_tlast),
    .q_full    (q_full),
    .in_ready  (in_tready),
    .push      (push),
    .push_job  (push_job)
  );

  sfr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  sfr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_valid  (head_valid),
    .head_job    (head_job),
    .pop         (pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_byte    (out_tdata),
    .out_present (out_tuser),
    .out_end     (out_tlast)
  );

endmodule
